// ----- hdl/d2dm_pkg.sv -----
`timescale 1ns / 1ps

package d2dm_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned FRAC_W = 52;
	localparam int unsigned BEXP_W = 11;
	localparam int unsigned EXP_W = 12;

	// exponent bias including the fraction width
	localparam logic [EXP_W-1:0] EXP_BIAS = 12'd1075;
	// -1074 in twelve bits
	localparam logic [EXP_W-1:0] SUBNORMAL_EXP = 12'hBCE;

	// divide by five is done sixteen bits at a time, high chunk first
	localparam int unsigned CHUNK_W = 16;
	localparam int unsigned NUM_CHUNKS = WORD_W / CHUNK_W;
	localparam int unsigned CNT_W = $clog2(NUM_CHUNKS);
	localparam int unsigned REM_W = 3;
	localparam int unsigned NUM_W = CHUNK_W + REM_W;

	// ceil(2^21 / 5), exact for every partial dividend below 5 * 2^16
	localparam int unsigned RECIP_W = 20;
	localparam logic [RECIP_W-1:0] RECIP5 = 20'h66667;
	localparam int unsigned RECIP_SHIFT = 21;
	localparam int unsigned PROD_W = NUM_W + RECIP_W;

	typedef struct packed {
		logic idle;
		logic done;
	} core_status_t;

	typedef struct packed {
		logic negative;
		logic [WORD_W-1:0] mantissa;
		logic [EXP_W-1:0] exponent;
	} result_t;

endpackage

// ----- hdl/d2dm_div5.sv -----
`timescale 1ns / 1ps

// one long-division step by five over a sixteen-bit chunk
module d2dm_div5 (
	input  logic [d2dm_pkg::REM_W-1:0]   rem_in,
	input  logic [d2dm_pkg::CHUNK_W-1:0] chunk,
	output logic [d2dm_pkg::CHUNK_W-1:0] quot,
	output logic [d2dm_pkg::REM_W-1:0]   rem_out
);

	logic [d2dm_pkg::NUM_W-1:0]  num;
	logic [d2dm_pkg::PROD_W-1:0] prod;
	logic [d2dm_pkg::NUM_W-1:0]  back;
	logic [d2dm_pkg::NUM_W-1:0]  diff;

	always_comb begin
		num = {rem_in, chunk};
		prod = {{d2dm_pkg::RECIP_W{1'b0}}, num} *
			{{d2dm_pkg::NUM_W{1'b0}}, d2dm_pkg::RECIP5};
		quot = prod[d2dm_pkg::RECIP_SHIFT +: d2dm_pkg::CHUNK_W];
		back = {1'b0, quot, 2'b00} + {3'b000, quot};
		diff = num - back;
		rem_out = diff[d2dm_pkg::REM_W-1:0];
	end

endmodule

// ----- hdl/d2dm_core.sv -----
`timescale 1ns / 1ps

module d2dm_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [d2dm_pkg::WORD_W-1:0] bits,
	input  logic                        ack,
	output d2dm_pkg::core_status_t      status,
	output d2dm_pkg::result_t           result
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]                        state_q;
	logic [d2dm_pkg::CNT_W-1:0]        cnt_q;
	logic [d2dm_pkg::REM_W-1:0]        rem_q;
	logic [d2dm_pkg::WORD_W-1:0]       mant_q;
	logic [d2dm_pkg::EXP_W-1:0]        bexp_q;
	logic [d2dm_pkg::EXP_W-1:0]        dexp_q;
	logic                              sign_q;

	logic [d2dm_pkg::BEXP_W-1:0]       field;
	logic [d2dm_pkg::CHUNK_W-1:0]      quot;
	logic [d2dm_pkg::REM_W-1:0]        rem_next;

	assign field = bits[d2dm_pkg::FRAC_W +: d2dm_pkg::BEXP_W];

	d2dm_div5 u_div5 (
		.rem_in  (rem_q),
		.chunk   (mant_q[d2dm_pkg::WORD_W-1 -: d2dm_pkg::CHUNK_W]),
		.quot    (quot),
		.rem_out (rem_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (bexp_q == '0) begin
						state_q <= ST_DONE;
					end else if (!bexp_q[d2dm_pkg::EXP_W-1] && mant_q[d2dm_pkg::WORD_W-1]) begin
						state_q <= ST_DIV;
						cnt_q <= '0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == d2dm_pkg::CNT_W'(d2dm_pkg::NUM_CHUNKS - 1)) state_q <= ST_RUN;
				end
				ST_DONE: begin
					if (ack) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					sign_q <= bits[d2dm_pkg::WORD_W-1];
					if (field != '0) begin
						bexp_q <= {1'b0, field} - d2dm_pkg::EXP_BIAS;
						dexp_q <= {1'b0, field} - d2dm_pkg::EXP_BIAS;
						mant_q <= {11'd0, 1'b1, bits[d2dm_pkg::FRAC_W-1:0]};
					end else begin
						bexp_q <= d2dm_pkg::SUBNORMAL_EXP;
						dexp_q <= d2dm_pkg::SUBNORMAL_EXP;
						mant_q <= {12'd0, bits[d2dm_pkg::FRAC_W-1:0]};
					end
				end
			end
			ST_RUN: begin
				if (bexp_q[d2dm_pkg::EXP_W-1]) begin
					// negative exponent: trade a factor of two for a factor of ten
					bexp_q <= bexp_q + 1'b1;
					if (|mant_q[d2dm_pkg::WORD_W-1 -: 3]) begin
						mant_q <= {1'b0, mant_q[d2dm_pkg::WORD_W-1:1]};
						dexp_q <= dexp_q + 1'b1;
					end else begin
						mant_q <= {mant_q[d2dm_pkg::WORD_W-3:0], 2'b00} + mant_q;
					end
				end else if (bexp_q != '0) begin
					if (mant_q[d2dm_pkg::WORD_W-1]) begin
						rem_q <= '0;
					end else begin
						mant_q <= {mant_q[d2dm_pkg::WORD_W-2:0], 1'b0};
						dexp_q <= dexp_q - 1'b1;
						bexp_q <= bexp_q - 1'b1;
					end
				end
			end
			ST_DIV: begin
				// top chunk goes into the divider, quotient chunk enters at the bottom
				mant_q <= {mant_q[d2dm_pkg::WORD_W-d2dm_pkg::CHUNK_W-1:0], quot};
				rem_q <= rem_next;
				if (cnt_q == d2dm_pkg::CNT_W'(d2dm_pkg::NUM_CHUNKS - 1)) bexp_q <= bexp_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign status.idle = (state_q == ST_IDLE);
	assign status.done = (state_q == ST_DONE);
	assign result.negative = sign_q;
	assign result.mantissa = mant_q;
	assign result.exponent = dexp_q;

endmodule

// ----- hdl/double_to_decimal_mantissa_exponent_unit.sv -----
`timescale 1ns / 1ps

// Converts raw binary64 bits to sign, 64-bit integer mantissa and signed decimal exponent
// (value ~ mantissa * 10^exponent, every step truncating). One beat is converted at a time.
// The binary exponent e is the unbiased one (-1074 for zero and subnormals, up to 972), and it
// is walked one unit per cycle, except while a divide by five runs, through a single
// shift/add unit; each divide by five takes a decision step and then a 16-bit long division,
// high chunk first. The input is stalled while a conversion runs and while a finished result
// waits for the output register; a finished result sits in the output register so the next
// beat can be taken while it waits there.
module double_to_decimal_mantissa_exponent_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [63:0]        double_bits,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               negative,
	output logic [63:0]        decimal_mantissa,
	output logic signed [11:0] decimal_exponent
);

	d2dm_pkg::core_status_t status;
	d2dm_pkg::result_t      result;
	logic                   take;
	logic                   out_valid_q;
	d2dm_pkg::result_t      out_q;

	assign in_stall = !status.idle;
	assign take = status.done && (!out_valid_q || !out_stall);

	d2dm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_valid && status.idle),
		.bits   (double_bits),
		.ack    (take),
		.status (status),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign negative = out_q.negative;
	assign decimal_mantissa = out_q.mantissa;
	assign decimal_exponent = $signed(out_q.exponent);

endmodule

// ----- tb/sv/d2dm_conversion_checker.sv -----
`timescale 1ns / 1ps

module d2dm_conversion_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [63:0]        double_bits,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               negative,
	input  logic [63:0]        decimal_mantissa,
	input  logic signed [11:0] decimal_exponent,
	output int                 mismatches,
	output int                 outstanding,
	output int                 compared
);

	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic [d2dm_pkg::WORD_W-1:0] source;
		d2dm_pkg::result_t want;
	} conversion_t;

	conversion_t pending_conversions [$];
	int mismatch_count = 0;
	int pending_count = 0;
	int results_seen = 0;

	assign mismatches = mismatch_count;
	assign outstanding = pending_count;
	assign compared = results_seen;

	// walks the binary exponent to zero, one unit per step, truncating every step
	function automatic d2dm_pkg::result_t convert_binary64(
			input logic [d2dm_pkg::WORD_W-1:0] bits);
		d2dm_pkg::result_t r;
		logic [d2dm_pkg::WORD_W-1:0] mant;
		int bexp;
		int dexp;
		mant = '0;
		mant[d2dm_pkg::FRAC_W-1:0] = bits[d2dm_pkg::FRAC_W-1:0];
		if (bits[d2dm_pkg::WORD_W-2:d2dm_pkg::FRAC_W] != '0) begin
			bexp = int'(bits[d2dm_pkg::WORD_W-2:d2dm_pkg::FRAC_W]) - int'(d2dm_pkg::EXP_BIAS);
			mant[d2dm_pkg::FRAC_W] = 1'b1;
		end else begin
			// zero and subnormals share the smallest exponent
			bexp = int'($signed(d2dm_pkg::SUBNORMAL_EXP));
		end
		dexp = bexp;
		while (bexp < 0) begin
			if (mant[d2dm_pkg::WORD_W-1 -: 3] != 3'b000) begin
				mant = mant >> 1;
				dexp++;
			end else begin
				mant = mant * 64'd5;
			end
			bexp++;
		end
		while (bexp > 0) begin
			if (mant[d2dm_pkg::WORD_W-1]) begin
				mant = mant / 64'd5;
			end else begin
				mant = mant << 1;
				dexp--;
			end
			bexp--;
		end
		r.negative = bits[d2dm_pkg::WORD_W-1];
		r.mantissa = mant;
		r.exponent = dexp[d2dm_pkg::EXP_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] source,
			input logic [63:0] got, input logic [63:0] want);
		if (mismatch_count < MAX_PRINTED) begin
			$display("%0t mismatch: %s, input %h: got %h, expected %h",
				$time, what, source, got, want);
		end
		mismatch_count++;
	endtask

	always @(posedge clk) begin : watch
		conversion_t entry;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				entry.source = double_bits;
				entry.want = convert_binary64(double_bits);
				pending_conversions.push_back(entry);
			end
			if (out_valid && !out_stall) begin
				if (pending_conversions.size() == 0) begin
					report_mismatch("result beat with nothing pending", '0,
						decimal_mantissa, '0);
				end else begin
					entry = pending_conversions.pop_front();
					if (negative !== entry.want.negative)
						report_mismatch("negative", entry.source, {63'd0, negative},
							{63'd0, entry.want.negative});
					if (decimal_mantissa !== entry.want.mantissa)
						report_mismatch("decimal_mantissa", entry.source, decimal_mantissa,
							entry.want.mantissa);
					if (decimal_exponent !== entry.want.exponent)
						report_mismatch("decimal_exponent", entry.source,
							{52'd0, decimal_exponent}, {52'd0, entry.want.exponent});
					results_seen++;
				end
			end
			pending_count <= pending_conversions.size();
		end
	end

endmodule

// ----- tb/sv/double_to_decimal_mantissa_exponent_unit_tb.sv -----
`timescale 1ns / 1ps

module double_to_decimal_mantissa_exponent_unit_tb;

	localparam int RANDOM_ITEMS = 480;
	localparam int BURST_ITEMS = 10;
	localparam int STEADY_ITEMS = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 2100;
	localparam logic [10:0] BIAS_FIELD = 11'd1075;
	localparam logic [10:0] SPECIAL_FIELD = 11'd2047;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [63:0] double_bits;
	logic out_valid;
	logic out_stall;
	logic negative;
	logic [63:0] decimal_mantissa;
	logic signed [11:0] decimal_exponent;

	int mismatches;
	int outstanding;
	int compared;

	int hold_requests = 0;
	logic no_idle;
	int n_tiny = 0;
	int n_special = 0;
	int n_up = 0;
	int n_down = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	double_to_decimal_mantissa_exponent_unit DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.double_bits      (double_bits),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.negative         (negative),
		.decimal_mantissa (decimal_mantissa),
		.decimal_exponent (decimal_exponent)
	);

	d2dm_conversion_checker conv_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.double_bits      (double_bits),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.negative         (negative),
		.decimal_mantissa (decimal_mantissa),
		.decimal_exponent (decimal_exponent),
		.mismatches       (mismatches),
		.outstanding      (outstanding),
		.compared         (compared)
	);

	// mostly short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic [63:0] random_double();
		logic [63:0] frac;
		logic [10:0] field;
		int r;
		frac = {$urandom, $urandom};
		r = $urandom_range(0, 99);
		if (r < 10) begin
			field = '0;
			if ($urandom_range(0, 3) == 0) frac = frac >> $urandom_range(0, 63);
		end else if (r < 18) begin
			field = SPECIAL_FIELD;
		end else if (r < 60) begin
			// binary exponent near zero keeps the conversion short
			field = BIAS_FIELD - 11'd64 + 11'($urandom_range(0, 128));
		end else if (r < 80) begin
			field = 11'($urandom_range(1, 2046));
		end else begin
			return {$urandom, $urandom};
		end
		return {1'($urandom), field, frac[51:0]};
	endfunction

	task automatic send_beat(input logic [63:0] bits);
		in_valid <= 1'b1;
		double_bits <= bits;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (bits[62:52] == '0) n_tiny++;
		else if (bits[62:52] == SPECIAL_FIELD) n_special++;
		else if (bits[62:52] >= BIAS_FIELD) n_up++;
		else n_down++;
	endtask

	task automatic idle_sender();
		int gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin : receiver
		int holds_done;
		holds_done = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests > holds_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				holds_done++;
			end else if (!no_idle && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat (pick_gap() + 1) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		logic [63:0] corners [$];
		int i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		double_bits = '0;
		no_idle = 1'b0;
		corners = '{
			64'h0000000000000000, 64'h8000000000000000,  // both zeros
			64'h0000000000000001, 64'h000FFFFFFFFFFFFF,  // subnormal ends
			64'h0010000000000000, 64'h3FF0000000000000,
			64'h4330000000000000, 64'hC33FFFFFFFFFFFFF,  // no scaling steps at all
			64'h4340000000000000, 64'h4320000000000000,  // one step up, one step down
			64'h7FEFFFFFFFFFFFFF, 64'hFFEFFFFFFFFFFFFF,
			64'h7FF0000000000000, 64'hFFF0000000000000,  // infinities
			64'h7FF8000000000000, 64'hFFFFFFFFFFFFFFFF, 64'h7FF0000000000001,
			64'h3FB999999999999A, 64'h7E37E43C8800759C,
			64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corners[k]) begin
			send_beat(corners[k]);
			idle_sender();
		end
		wait_drained();

		// output held off while fast beats keep coming, so the input backs up
		hold_requests++;
		for (i = 0; i < BURST_ITEMS; i++)
			send_beat({1'($urandom), BIAS_FIELD - 11'd4 + 11'($urandom_range(0, 8)),
				52'({$urandom, $urandom})});
		wait_drained();

		no_idle = 1'b1;
		for (i = 0; i < STEADY_ITEMS; i++) send_beat(random_double());
		no_idle = 1'b0;

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			send_beat(random_double());
			idle_sender();
			if (i % 100 == 99) wait_drained();
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("converted %0d patterns: %0d zero/subnormal, %0d inf/nan, %0d up, %0d down",
			n_tiny + n_special + n_up + n_down, n_tiny, n_special, n_up, n_down);
		$display("%0d results compared, output held off %0d cycles once to back up the input",
			compared, HOLD_CYCLES);
		if (outstanding != 0)
			$display("%0d results never arrived", outstanding);
		if (mismatches == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin : run_limit
		#(50_000_000);
		$display("timeout with %0d results still pending", outstanding);
		$display("TB_ERROR");
		$finish;
	end

endmodule
